/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the value list.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset disable.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Implication from one cycle to the next.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  `ASSERT_CLK(label, clk_sig, rst_sig, (ante) |=> (cons), msg)

`endif

/* rtl/core/cvl_pkg.sv */
// Types and codes for the compacting value list.
// No dependencies; imported by cvl_cell, compacting_value_list and the test files.
package cvl_pkg;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned CNT_W  = 5;

  typedef logic signed [DATA_W-1:0] data_t;

  // Broadcast to every cell during the execute cycle.
  typedef struct packed {
    logic  append;
    logic  remove;
    data_t key;
  } cvl_cmd_t;

endpackage

/* rtl/core/compacting_value_list.sv */
// Compacting value list: a row of cells, one per entry, with append and remove.
// done rises after the execute cycle: start sets pend (busy), then pend sets done.
// A new item is not taken while busy; busy covers the cycle in which the cell
// row compares, resolves the first match along its hit chain and shifts.
// Reset (rst, synchronous): the list is empty; entries keep old contents.
// Depends on cvl_pkg, cvl_cell and assert_macros.svh.
`include "assert_macros.svh"

module compacting_value_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic signed [31:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  position,
  output logic [4:0]  count
);
  import cvl_pkg::*;

  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W  = $clog2(CAPACITY);

  logic              pend;
  op_t               op_q;
  data_t             key_q;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  cvl_cmd_t          cmd;
  data_t             cell_data [CAPACITY];
  logic [CAPACITY:0] hit_chain;
  logic [CAPACITY-1:0] first_vec;
  logic [IDX_W-1:0]  hit_pos;
  logic              is_full;
  logic              found;

  status_t           res_status;
  logic [IDX_W-1:0]  res_pos;

  assign busy = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= start & ~pend;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !pend) begin
      op_q  <= op_t'(opcode);
      key_q <= value;
    end
  end

  assign is_full = (fill == FILL_W'(CAPACITY));
  assign found   = hit_chain[CAPACITY];

  always_comb begin
    cmd.append = pend && (op_q == OP_APPEND) && !is_full;
    cmd.remove = pend && (op_q == OP_REMOVE);
    cmd.key    = key_q;
  end

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t right_d;
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid
      assign right_d = cell_data[i+1];
    end
    cvl_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .in_use     (FILL_W'(i) < fill),
      .tail       (FILL_W'(i) == fill),
      .hit_in     (hit_chain[i]),
      .right_data (right_d),
      .data       (cell_data[i]),
      .hit_out    (hit_chain[i+1]),
      .first_hit  (first_vec[i])
    );
  end

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_pos = hit_pos | (first_vec[i] ? IDX_W'(i) : '0);
    end
  end

  always_comb begin
    res_status = ST_DONE;
    res_pos    = '0;
    fill_next  = fill;
    if (op_q == OP_APPEND) begin
      if (is_full) begin
        res_status = ST_FULL;
      end else begin
        res_pos   = fill[IDX_W-1:0];
        fill_next = fill + FILL_W'(1);
      end
    end else begin
      if (found) begin
        res_pos   = hit_pos;
        fill_next = fill - FILL_W'(1);
      end else begin
        res_status = ST_NOTFOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      done <= 1'b0;
    end else begin
      done <= pend;
      if (pend) begin
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      status   <= res_status;
      position <= 4'(res_pos);
      count    <= 5'(fill_next);
    end
  end

  `ASSERT_CLK(a_fill_bound, clk, rst, fill <= FILL_W'(CAPACITY), "fill above capacity")
  `ASSERT_NEXT(a_fill_hold, clk, rst, !pend, fill == $past(fill), "fill moved while idle")
  `ASSERT_CLK(a_done_after_busy, clk, rst, done |-> $past(pend), "done without execute cycle")
  `ASSERT_NEXT(a_hit_consistent, clk, rst, pend && op_q == OP_REMOVE && found,
               count == 5'($past(fill) - FILL_W'(1)), "remove count mismatch")

endmodule

/* rtl/core/cvl_cell.sv */
// One list slot: holds an entry, compares it with the key and shifts down.
// Depends on cvl_pkg.
module cvl_cell (
  input  logic             clk,
  input  cvl_pkg::cvl_cmd_t cmd,
  input  logic             in_use,
  input  logic             tail,
  input  logic             hit_in,
  input  cvl_pkg::data_t   right_data,
  output cvl_pkg::data_t   data,
  output logic             hit_out,
  output logic             first_hit
);
  import cvl_pkg::*;

  logic match;

  assign match     = in_use && (data == cmd.key);
  assign hit_out   = hit_in | match;
  assign first_hit = match & ~hit_in;

  always_ff @(posedge clk) begin
    if (cmd.append && tail) begin
      data <= cmd.key;
    end else if (cmd.remove && hit_out) begin
      data <= right_data;
    end
  end

endmodule

/* test/cvl_result_check.sv */
`timescale 1ns / 100ps
// Result checker for compacting_value_list: keeps its own copy of the list,
// predicts one result per accepted item and compares it at each done strobe.
// Depends on cvl_pkg.
module cvl_result_check #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        opcode,
  input  logic [31:0] value,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [3:0]  position,
  input  logic [4:0]  count,
  output int          errors,
  output int          outstanding
);
  import cvl_pkg::*;

  typedef struct packed {
    status_t          st;
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } list_result_t;

  logic [DATA_W-1:0] slots [CAPACITY];
  int unsigned       fill;
  list_result_t      pending_results [$];
  int                mismatch_n = 0;

  function automatic list_result_t apply_list_op(input logic op,
                                                 input logic [DATA_W-1:0] key);
    list_result_t r;
    int           hit;
    hit   = -1;
    r.st  = ST_DONE;
    r.pos = '0;
    r.cnt = '0;
    if (op == OP_APPEND) begin
      if (fill >= CAPACITY) begin
        r.st  = ST_FULL;
        r.cnt = fill[CNT_W-1:0];
      end else begin
        slots[fill] = key;
        r.pos = fill[POS_W-1:0];
        fill  = fill + 1;
        r.cnt = fill[CNT_W-1:0];
      end
    end else begin
      for (int i = 0; i < fill; i++) begin
        if (hit < 0 && slots[i] == key) hit = i;
      end
      if (hit < 0) begin
        r.st  = ST_NOTFOUND;
        r.cnt = fill[CNT_W-1:0];
      end else begin
        for (int i = hit; i + 1 < fill; i++) slots[i] = slots[i+1];
        fill  = fill - 1;
        r.pos = hit[POS_W-1:0];
        r.cnt = fill[CNT_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic report(input string what, input int unsigned got,
                        input int unsigned want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatch_n++;
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      fill = 0;
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report("unexpected result, status", status, 0);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.st) report("status", status, want.st);
          if (position !== want.pos) report("position", position, want.pos);
          if (count !== want.cnt) report("count", count, want.cnt);
        end
      end
      if (start && !busy) pending_results.push_back(apply_list_op(opcode, value));
    end
    outstanding <= pending_results.size();
    errors      <= mismatch_n;
  end

endmodule

/* test/compacting_value_list_tb.sv */
`timescale 1ns / 100ps
// Stimulus and verdict for compacting_value_list: directed list corner cases,
// then random append/remove phases. Depends on the block and cvl_result_check.
module compacting_value_list_tb;
  import cvl_pkg::*;

  localparam int unsigned CAPACITY   = 16;
  localparam int          IDLE_LIMIT = 2000;

  logic        clk    = 1'b0;
  logic        rst    = 1'b1;
  logic        start  = 1'b0;
  logic        opcode = 1'b0;
  logic [31:0] value  = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  position;
  logic [4:0]  count;
  int          errors;
  int          outstanding;
  int          idle_cycles = 0;

  logic [31:0] pool [8];
  logic [31:0] tail_val;

  compacting_value_list #(.CAPACITY(CAPACITY)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .value(value), .done(done), .status(status), .position(position),
    .count(count)
  );

  cvl_result_check #(.CAPACITY(CAPACITY)) result_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .value(value), .done(done), .status(status), .position(position),
    .count(count), .errors(errors), .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic int draw_gap(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 16);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
  endfunction

  task automatic send_item(input logic op, input logic [31:0] val, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start  <= 1'b1;
    opcode <= op;
    value  <= val;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_phase(input int n_items, input int append_pct, input int gap_mode);
    logic        op;
    logic [31:0] val;
    int          pick;
    for (int k = 0; k < n_items; k++) begin
      op   = ($urandom_range(1, 100) <= append_pct) ? OP_APPEND : OP_REMOVE;
      pick = $urandom_range(1, 10);
      if (op == OP_APPEND) begin
        if (pick == 1) begin
          val      = $urandom;
          tail_val = val;
        end else begin
          val = pool[$urandom_range(0, 7)];
        end
      end else begin
        if (pick == 1) val = $urandom;
        else if (pick == 2) val = tail_val;
        else val = pool[$urandom_range(0, 7)];
      end
      send_item(op, val, draw_gap(gap_mode));
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) pool[i] = $urandom;
    pool[0]  = 32'h8000_0000;
    pool[1]  = 32'h7FFF_FFFF;
    tail_val = $urandom;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list, extremes, duplicates, fill to full, removes at both ends
    send_item(OP_REMOVE, 32'h0000_0000, draw_gap(2));
    send_item(OP_APPEND, 32'h8000_0000, draw_gap(2));
    send_item(OP_APPEND, 32'h7FFF_FFFF, draw_gap(2));
    send_item(OP_APPEND, 32'h0000_0000, draw_gap(2));
    send_item(OP_APPEND, 32'hFFFF_FFFF, draw_gap(2));
    send_item(OP_APPEND, 32'd5, draw_gap(2));
    send_item(OP_APPEND, 32'd5, draw_gap(2));
    send_item(OP_REMOVE, 32'd1, draw_gap(2));
    send_item(OP_REMOVE, 32'd5, draw_gap(2));
    repeat (11) begin
      tail_val = $urandom;
      send_item(OP_APPEND, tail_val, draw_gap(2));
    end
    send_item(OP_APPEND, 32'h1234_5678, draw_gap(2));
    send_item(OP_REMOVE, 32'h8000_0000, draw_gap(2));
    send_item(OP_REMOVE, tail_val, draw_gap(2));
    send_item(OP_REMOVE, 32'd5, draw_gap(2));
    send_item(OP_REMOVE, 32'hFFFF_FFFF, draw_gap(2));
    send_item(OP_REMOVE, 32'h7FFF_FFFF, draw_gap(2));
    drain_results();

    for (int ph = 0; ph < 14; ph++) begin
      pool[$urandom_range(2, 7)] = $urandom;
      run_phase(123, (ph == 13) ? 50 : ((ph % 2) ? 35 : 65), ph % 3);
      if (ph % 4 == 3) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
